@@ src/assert_macros.svh @@
// Shared assertion macros. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dht_pkg.sv @@
package dht_pkg;

	localparam int TABLE_SIZE   = 1021;
	localparam int ALIGN_DIV    = 8;
	localparam int LOAD_DIVISOR = 3;

	localparam int KEY_W      = 32;
	localparam int VALUE_W    = 16;
	localparam int SLOT_OUT_W = 10;

	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int LOAD_LIMIT = TABLE_SIZE / LOAD_DIVISOR;
	localparam int CNT_W      = $clog2(LOAD_LIMIT + 1);

	// home/step = (x mod (ALIGN_DIV*TABLE_SIZE)) / ALIGN_DIV
	localparam int MOD_C   = ALIGN_DIV * TABLE_SIZE;
	localparam int MOD_W   = $clog2(MOD_C);
	localparam int MOD_C_W = $clog2(MOD_C + 1);
	localparam int QUO_W   = KEY_W + 1 - MOD_C_W;
	localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / MOD_C);
	localparam logic [MOD_C_W-1:0] MOD_C_V = MOD_C_W'(MOD_C);

	// exact reciprocal of ALIGN_DIV for values below 2**MOD_W
	localparam int DIV_S   = MOD_W + $clog2(ALIGN_DIV);
	localparam int DIV_M_W = DIV_S + 1;
	localparam logic [DIV_M_W-1:0] DIV_M =
		DIV_M_W'(((64'd1 << DIV_S) + ALIGN_DIV - 1) / ALIGN_DIV);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(LOAD_LIMIT);

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] insert_value;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic                  inserted;
		logic                  full_res;
		logic [SLOT_OUT_W-1:0] slot;
		logic [VALUE_W-1:0]    stored_value;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [SLOT_W-1:0]  home;
		logic [SLOT_W-1:0]  step;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ src/double_hash_key_table.sv @@
// Open-addressing key table with double hashing. Each req beat is a lookup of
// key; if absent, key and insert_value are stored, unless the table already
// holds TABLE_SIZE/3 entries or the probe sequence finds no free slot, in
// which case full_res is returned and nothing changes. Exactly one rsp beat
// answers each req beat, in order. After reset every slot of the table is swept
// clear with req_stall high. A request then passes through the hash unit (reciprocal
// multiply, multiply back by the modulus, subtract, correct, scale) and then the
// probe engine, which takes a READ and a CHECK state per probe for the registered
// table read. A two-beat queue between them overlaps the two, so the hash unit can
// take a new request while the probe engine still works on earlier ones.
module double_hash_key_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dht_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dht_pkg::rsp_t rsp
);
	import dht_pkg::*;

	logic      ready;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      pop_job;
	q_status_t q_stat;

	dht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.ready     (ready),
		.push      (push),
		.push_job  (push_job),
		.q_stat    (q_stat)
	);

	dht_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	dht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ready     (ready),
		.q_empty   (q_stat.empty),
		.pop       (pop),
		.pop_job   (pop_job),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ src/dht_front.sv @@
`include "assert_macros.svh"

module dht_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dht_pkg::req_t   req,
	input  logic            ready,
	output logic            push,
	output dht_pkg::job_t   push_job,
	input  dht_pkg::q_status_t q_stat
);
	import dht_pkg::*;

	localparam int LANES = 2; // lane 0: home, lane 1: step

	typedef enum logic [2:0] {
		F_IDLE, F_MUL1, F_MUL2, F_SUB, F_FIX, F_DIV, F_PUSH
	} fstate_t;

	fstate_t state_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [KEY_W-1:0]   x_q   [LANES];
	logic [QUO_W-1:0]   qe_q  [LANES];
	logic [KEY_W-1:0]   acc_q [LANES];
	logic [SLOT_W-1:0]  idx_q [LANES];

	logic [2*KEY_W-1:0]         mul1 [LANES];
	logic [QUO_W+MOD_C_W-1:0]   mul2 [LANES];
	logic [MOD_W+DIV_M_W-1:0]   mul3 [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mul1[l] = (2*KEY_W)'(x_q[l]) * (2*KEY_W)'(RECIP);
			mul2[l] = (QUO_W+MOD_C_W)'(qe_q[l]) * (QUO_W+MOD_C_W)'(MOD_C_V);
			mul3[l] = (MOD_W+DIV_M_W)'(acc_q[l][MOD_W-1:0]) * (MOD_W+DIV_M_W)'(DIV_M);
		end
	end

	assign req_stall = (state_q != F_IDLE) || !ready;
	assign push      = (state_q == F_PUSH) && !q_stat.full;

	always_comb begin
		push_job.key   = key_q;
		push_job.value = value_q;
		push_job.home  = idx_q[0];
		push_job.step  = (idx_q[1] == '0) ? SLOT_W'(1) : idx_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req_valid && !req_stall) begin
						key_q   <= req.key;
						value_q <= req.insert_value;
						x_q[0]  <= req.key;
						x_q[1]  <= ~req.key;
						state_q <= F_MUL1;
					end
				end
				F_MUL1: begin
					// quotient estimate, low by at most one
					for (int l = 0; l < LANES; l++)
						qe_q[l] <= mul1[l][KEY_W +: QUO_W];
					state_q <= F_MUL2;
				end
				F_MUL2: begin
					for (int l = 0; l < LANES; l++)
						acc_q[l] <= KEY_W'(mul2[l]);
					state_q <= F_SUB;
				end
				F_SUB: begin
					for (int l = 0; l < LANES; l++)
						acc_q[l] <= x_q[l] - acc_q[l];
					state_q <= F_FIX;
				end
				F_FIX: begin
					for (int l = 0; l < LANES; l++)
						if (acc_q[l] >= KEY_W'(MOD_C))
							acc_q[l] <= acc_q[l] - KEY_W'(MOD_C);
					state_q <= F_DIV;
				end
				F_DIV: begin
					for (int l = 0; l < LANES; l++)
						idx_q[l] <= SLOT_W'(mul3[l] >> DIV_S);
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_stat.full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall && (state_q == F_MUL1), "front took a beat but is not hashing it")

endmodule

@@ src/dht_queue.sv @@
`include "assert_macros.svh"

module dht_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dht_pkg::job_t      push_job,
	input  logic               pop,
	output dht_pkg::job_t      pop_job,
	output dht_pkg::q_status_t q_stat
);
	import dht_pkg::*;

	job_t            buf_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == Q_CW'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_job      = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`ASSERT_CLK(a_no_overrun, !(push && q_stat.full) && !(pop && q_stat.empty), "queue overrun or underrun")
	`ASSERT_NEXT(a_count_track, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

@@ src/dht_back.sv @@
`include "assert_macros.svh"

module dht_back (
	input  logic          clk,
	input  logic          arst_n,
	output logic          ready,
	input  logic          q_empty,
	output logic          pop,
	input  dht_pkg::job_t pop_job,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dht_pkg::rsp_t rsp
);
	import dht_pkg::*;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK} bstate_t;

	entry_t mem [TABLE_SIZE];
	entry_t rd_q;

	bstate_t            state_q;
	logic [SLOT_W-1:0]  addr_q;
	logic [SLOT_W-1:0]  step_q;
	logic [SLOT_W-1:0]  probes_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic match, empty_slot, exhausted, resolve, out_free, commit, do_insert;
	logic [SLOT_W:0]    sum;
	logic [SLOT_W-1:0]  next_addr;
	rsp_t               res_d;
	logic               wr_en;
	entry_t             wr_data;
	logic [2:0]         outcome;

	assign match      = rd_q.valid && (rd_q.key == key_q);
	assign empty_slot = !rd_q.valid;
	assign exhausted  = !match && !empty_slot && (probes_q == SLOT_LAST);
	assign resolve    = match || empty_slot || exhausted;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign commit     = (state_q == B_CHECK) && resolve && out_free;
	assign do_insert  = empty_slot && (cnt_q < CNT_LIMIT);

	assign sum       = (SLOT_W+1)'(addr_q) + (SLOT_W+1)'(step_q);
	assign next_addr = (sum >= (SLOT_W+1)'(TABLE_SIZE)) ?
		SLOT_W'(sum - (SLOT_W+1)'(TABLE_SIZE)) : SLOT_W'(sum);

	always_comb begin
		res_d.hit          = match;
		res_d.inserted     = do_insert;
		res_d.full_res     = !match && !do_insert;
		res_d.slot         = (match || do_insert) ? SLOT_OUT_W'(addr_q) : '0;
		res_d.stored_value = match ? rd_q.value : (do_insert ? value_q : '0);
	end

	// sweep reuses addr_q as its counter
	assign wr_en = (state_q == B_CLEAR) || (commit && do_insert);
	always_comb begin
		if (state_q == B_CLEAR) begin
			wr_data = '0;
		end else begin
			wr_data.valid = 1'b1;
			wr_data.key   = key_q;
			wr_data.value = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_q] <= wr_data;
		rd_q <= mem[addr_q];
	end

	assign ready     = (state_q != B_CLEAR);
	assign pop       = (state_q == B_IDLE) && !q_empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			addr_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (commit && do_insert)
				cnt_q <= cnt_q + 1'b1;

			unique case (state_q)
				B_CLEAR: begin
					if (addr_q == SLOT_LAST)
						state_q <= B_IDLE;
					else
						addr_q <= addr_q + 1'b1;
				end
				B_IDLE: begin
					if (pop) begin
						addr_q   <= pop_job.home;
						step_q   <= pop_job.step;
						key_q    <= pop_job.key;
						value_q  <= pop_job.value;
						probes_q <= '0;
						state_q  <= B_READ;
					end
				end
				B_READ: state_q <= B_CHECK;
				B_CHECK: begin
					if (resolve) begin
						// hold here until the output register frees up
						if (out_free)
							state_q <= B_IDLE;
					end else begin
						addr_q   <= next_addr;
						probes_q <= probes_q + 1'b1;
						state_q  <= B_READ;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign outcome = {rsp_q.hit, rsp_q.inserted, rsp_q.full_res};

	`ASSERT_CLK(a_one_outcome, !rsp_valid_q || $onehot(outcome), "result beat has not exactly one outcome")
	`ASSERT_NEXT(a_count_step, commit && do_insert, cnt_q == $past(cnt_q) + 1'b1, "insert did not bump entry count")
	`ASSERT_NEXT(a_clear_once, ready, ready, "table sweep restarted outside reset")

endmodule
